@@ rtl/core/naht_pkg.sv @@
// Shared types and constants for the node append health tracker.
package naht_pkg;

  // Node table geometry.
  localparam int NODE_COUNT = 64;
  localparam int NODE_AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  // Fixed field widths.
  localparam int TIME_W = 32;
  localparam int IDX_IN_W = 6;
  localparam int STATE_W = 2;
  localparam int ENTRY_W = TIME_W + STATE_W;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration register map (word index taken from paddr[2]).
  localparam logic REG_RECOVERY_INTERVAL = 1'b0;

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_QUERY   = 2'd0,
    CMD_SUCCESS = 2'd1,
    CMD_FAILURE = 2'd2
  } cmd_t;

  // Failure status codes.
  typedef enum logic [1:0] {
    STATUS_REAL_FAILURE = 2'd0,
    STATUS_PREEMPTED    = 2'd1,
    STATUS_ACCESS       = 2'd2,
    STATUS_NOT_IN_CONFIG = 2'd3
  } status_t;

  // Node health states.
  typedef enum logic [STATE_W-1:0] {
    HS_HEALTHY    = 2'd0,
    HS_FAILED     = 2'd1,
    HS_RECOVERING = 2'd2
  } health_t;

  // Operation after classification by the front.
  typedef enum logic [1:0] {
    OP_QUERY   = 2'd0,
    OP_SUCCESS = 2'd1,
    OP_FAIL    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // Back-end sequencer states.
  typedef enum logic {
    B_IDLE = 1'b0,
    B_EXEC = 1'b1
  } bstate_t;

  typedef logic [NODE_AW-1:0] node_idx_t;

  // One classified item as it sits in the queue.
  typedef struct packed {
    op_t              op;
    logic             in_range;
    node_idx_t        idx;
    logic [TIME_W-1:0] now;
  } item_t;

endpackage

@@ rtl/core/node_append_health_tracker.sv @@
// Top level of the node append health tracker: register port and front/back pipeline.
//
//  Channel   Direction  Transaction                Fields (low bit first)
//  s_*       in         probe/success/failure      tuser: command; tdata: node_index,
//                                                  now_time, status_code
//  m_*       out        one result per item        tdata: probe, node_state_after
//  APB       in/out     register write/read        word 0: recovery_interval
//
// In the back end, each item first reads the node table RAM (registered read port)
// in the idle state, then applies the transition, writes back and loads the output
// register in the execute state; no new item is taken before the current one is done.
// A two-entry queue in front keeps accepting until it is full while the back end
// or the output stalls. Reset clears all table valid bits at once, so no clearing
// pass is needed; recovery_interval resets to zero. With an idle back end, a result
// is valid once its item has passed the queue, the table read and the output register.
module node_append_health_tracker (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // node_index[5:0], now_time[37:6], status_code[39:38]
  input  logic [1:0]  s_tuser,   // command[1:0]
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // probe[0], node_state_after[2:1], zero[7:3]
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [naht_pkg::TIME_W-1:0] recovery_interval;
  logic                        q_valid;
  logic                        q_ready;
  naht_pkg::item_t             q_item;
  logic                        reg_sel;

  // Register access decode.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == naht_pkg::REG_RECOVERY_INTERVAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      recovery_interval <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      recovery_interval <= pwdata;
    end
  end

  assign prdata = reg_sel ? recovery_interval : '0;

  naht_front u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  naht_back u_back (
    .clk              (clk),
    .rst              (rst),
    .recovery_interval(recovery_interval),
    .q_valid          (q_valid),
    .q_ready          (q_ready),
    .q_item           (q_item),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata)
  );

endmodule

@@ rtl/core/naht_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module naht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(DEPTH)-1:0]       waddr,
  input  logic [WIDTH-1:0]               wdata,
  input  logic                           re,
  input  logic [$clog2(DEPTH)-1:0]       raddr,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/naht_front.sv @@
// Front end: accepts input transactions, classifies them and queues them.
module naht_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [39:0]         s_tdata,
  input  logic [1:0]          s_tuser,
  output logic                q_valid,
  input  logic                q_ready,
  output naht_pkg::item_t     q_item
);

  naht_pkg::cmd_t               cmd;
  naht_pkg::status_t            status;
  logic [naht_pkg::IDX_IN_W-1:0] raw_idx;
  naht_pkg::item_t              item_in;
  naht_pkg::item_t              q_mem [naht_pkg::QUEUE_DEPTH];
  logic [naht_pkg::QPTR_W-1:0]  wr_ptr;
  logic [naht_pkg::QPTR_W-1:0]  rd_ptr;
  logic [naht_pkg::QCNT_W-1:0]  count;
  logic                         push;
  logic                         pop;

  // Unpack the transaction fields.
  assign cmd     = naht_pkg::cmd_t'(s_tuser);
  assign raw_idx = s_tdata[5:0];
  assign status  = naht_pkg::status_t'(s_tdata[39:38]);

  // Classify: ignorable failures and the unused command change nothing.
  always_comb begin
    item_in.idx      = naht_pkg::NODE_AW'(raw_idx);
    item_in.now      = s_tdata[37:6];
    item_in.in_range = (32'(raw_idx) < 32'(naht_pkg::NODE_COUNT));
    case (cmd)
      naht_pkg::CMD_QUERY:   item_in.op = naht_pkg::OP_QUERY;
      naht_pkg::CMD_SUCCESS: item_in.op = naht_pkg::OP_SUCCESS;
      naht_pkg::CMD_FAILURE: begin
        if (status inside {naht_pkg::STATUS_PREEMPTED, naht_pkg::STATUS_ACCESS,
                           naht_pkg::STATUS_NOT_IN_CONFIG}) begin
          item_in.op = naht_pkg::OP_NONE;
        end else begin
          item_in.op = naht_pkg::OP_FAIL;
        end
      end
      default:               item_in.op = naht_pkg::OP_NONE;
    endcase
  end

  // Queue handshakes.
  assign s_tready = (count != naht_pkg::QCNT_W'(naht_pkg::QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;
  assign q_item   = q_mem[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= item_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // The fill count never passes the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= naht_pkg::QCNT_W'(naht_pkg::QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  // Simultaneous push and pop leave the fill count unchanged.
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    (push && pop) |=> $stable(count))
    else $error("queue count moved on push and pop");

  // A push alone raises the fill count by one.
  a_count_push: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not grow on push");

endmodule

@@ rtl/core/naht_back.sv @@
// Back end: reads the node table, applies the transition and returns the result.
module naht_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [naht_pkg::TIME_W-1:0]  recovery_interval,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  naht_pkg::item_t              q_item,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [7:0]                   m_tdata
);

  naht_pkg::bstate_t                  bstate;
  naht_pkg::bstate_t                  bstate_next;
  naht_pkg::item_t                    cur;
  logic [naht_pkg::NODE_COUNT-1:0]    valid;
  logic                               rd_valid;
  logic                               pop;
  logic                               out_free;
  logic                               exec_fire;
  logic [naht_pkg::ENTRY_W-1:0]       rdata;
  logic [naht_pkg::ENTRY_W-1:0]       wdata;
  logic                               ram_we;
  naht_pkg::health_t                  cur_st;
  logic [naht_pkg::TIME_W-1:0]        cur_dl;
  logic [naht_pkg::TIME_W:0]          dl_sum;
  logic [naht_pkg::TIME_W-1:0]        dl_sat;
  naht_pkg::health_t                  st_new;
  logic [naht_pkg::TIME_W-1:0]        dl_new;
  logic                               probe_new;
  logic                               out_probe;
  naht_pkg::health_t                  out_state;

  // Next-state logic of the sequencer.
  always_comb begin
    bstate_next = bstate;
    case (bstate)
      naht_pkg::B_IDLE: begin
        if (q_valid) begin
          bstate_next = naht_pkg::B_EXEC;
        end
      end
      naht_pkg::B_EXEC: begin
        if (out_free) begin
          bstate_next = naht_pkg::B_IDLE;
        end
      end
      default: bstate_next = naht_pkg::B_IDLE;
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    q_ready   = 1'b0;
    exec_fire = 1'b0;
    case (bstate)
      naht_pkg::B_IDLE: q_ready   = 1'b1;
      naht_pkg::B_EXEC: exec_fire = out_free;
      default: begin
        q_ready   = 1'b0;
        exec_fire = 1'b0;
      end
    endcase
  end

  assign pop      = q_valid && q_ready;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate <= naht_pkg::B_IDLE;
    end else begin
      bstate <= bstate_next;
    end
  end

  // Hold the item being worked on and sample the entry's valid bit.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur      <= q_item;
      rd_valid <= valid[q_item.idx];
    end
  end

  // Node table: deadline in the upper bits, health state in the lower bits.
  naht_ram #(
    .WIDTH(naht_pkg::ENTRY_W),
    .DEPTH(naht_pkg::NODE_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cur.idx),
    .wdata(wdata),
    .re   (pop),
    .raddr(q_item.idx),
    .rdata(rdata)
  );

  // An entry never written reads as healthy.
  assign cur_st = rd_valid ? naht_pkg::health_t'(rdata[naht_pkg::STATE_W-1:0])
                           : naht_pkg::HS_HEALTHY;
  assign cur_dl = rdata[naht_pkg::ENTRY_W-1:naht_pkg::STATE_W];

  // Saturating deadline for a node entering recovery.
  assign dl_sum = {1'b0, cur.now} + {1'b0, recovery_interval};
  assign dl_sat = dl_sum[naht_pkg::TIME_W] ? '1 : dl_sum[naht_pkg::TIME_W-1:0];

  // State transition and probe answer.
  always_comb begin
    st_new    = cur_st;
    dl_new    = cur_dl;
    probe_new = 1'b0;
    if (!cur.in_range) begin
      st_new = naht_pkg::HS_HEALTHY;
    end else begin
      case (cur.op)
        naht_pkg::OP_QUERY: begin
          probe_new = (cur_st == naht_pkg::HS_FAILED) ||
                      ((cur_st == naht_pkg::HS_RECOVERING) && (cur.now < cur_dl));
        end
        naht_pkg::OP_SUCCESS: begin
          if (cur_st == naht_pkg::HS_FAILED) begin
            st_new = naht_pkg::HS_RECOVERING;
            dl_new = dl_sat;
          end else if ((cur_st == naht_pkg::HS_RECOVERING) && (cur.now >= cur_dl)) begin
            st_new = naht_pkg::HS_HEALTHY;
          end
        end
        naht_pkg::OP_FAIL: st_new = naht_pkg::HS_FAILED;
        default: st_new = cur_st;
      endcase
    end
  end

  assign ram_we = exec_fire && cur.in_range;
  assign wdata  = {dl_new, st_new};

  // Valid bits mark table entries that have been written since reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ram_we) begin
      valid[cur.idx] <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_probe <= probe_new;
      out_state <= st_new;
    end
  end

  assign m_tdata = {5'b0, out_state, out_probe};

  // A result never carries the unused state code.
  a_state_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:1] != 2'd3))
    else $error("result carries an unused state code");

  // Only a query can ask for a probe.
  a_probe_query: assert property (@(posedge clk) disable iff (rst)
    (exec_fire && probe_new) |-> (cur.op == naht_pkg::OP_QUERY))
    else $error("probe raised for a non-query");

  // A fetched item always reaches execution in the next cycle.
  a_pop_exec: assert property (@(posedge clk) disable iff (rst)
    pop |=> (bstate == naht_pkg::B_EXEC))
    else $error("popped item not executed");

  // A blocked result keeps the item in execution and leaves the table alone.
  a_exec_hold: assert property (@(posedge clk) disable iff (rst)
    ((bstate == naht_pkg::B_EXEC) && !out_free) |-> !ram_we ##1
    (bstate == naht_pkg::B_EXEC))
    else $error("execution left while result blocked");

endmodule
